[design/binary_gcd_core_assert.svh]
// Assertion macros for the binary GCD core.
`ifndef BINARY_GCD_CORE_ASSERT_SVH
`define BINARY_GCD_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BGCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bgcd check failed");

// Next-cycle implication, checked out of reset.
`define BGCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bgcd check failed");

`endif

[design/bgcd_pkg.sv]
// Shared types and constants for the binary GCD core.
`timescale 1ns / 1ps
`default_nettype none

package bgcd_pkg;

  localparam int unsigned DataW        = 64;
  localparam int unsigned DefaultWidth = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVEN,
    ST_STRIP,
    ST_REDUCE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic merge;
    logic halve_both;
    logic halve_a;
    logic halve_b;
    logic sub;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
  } status_t;

endpackage

`default_nettype wire

[design/bgcd_datapath.sv]
// Operand registers, shift counter, subtractor and result register.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_datapath #(
  parameter int unsigned WIDTH = bgcd_pkg::DefaultWidth
) (
  input  wire logic                         clk_i,
  input  wire bgcd_pkg::cmd_t               cmd_i,
  input  wire logic [bgcd_pkg::DataW-1:0]   operand_a_i,
  input  wire logic [bgcd_pkg::DataW-1:0]   operand_b_i,
  output bgcd_pkg::status_t                 status_o,
  output logic [bgcd_pkg::DataW-1:0]        divisor_o
);
  import bgcd_pkg::*;

  localparam int unsigned ShiftW = $clog2(WIDTH);

  logic [WIDTH-1:0]  a_q, a_d;
  logic [WIDTH-1:0]  b_q, b_d;
  logic [WIDTH-1:0]  res_q, res_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic [WIDTH:0]    diff_ba;
  logic [WIDTH-1:0]  diff_ab;

  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
  assign diff_ab = a_q - b_q;

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    shift_d = shift_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      a_d     = operand_a_i[WIDTH-1:0];
      b_d     = operand_b_i[WIDTH-1:0];
      shift_d = '0;
    end
    if (cmd_i.merge) begin
      a_d = a_q | b_q;
    end
    if (cmd_i.halve_both) begin
      a_d     = a_q >> 1;
      b_d     = b_q >> 1;
      shift_d = shift_q + ShiftW'(1);
    end
    if (cmd_i.halve_a) begin
      a_d = a_q >> 1;
    end
    if (cmd_i.halve_b) begin
      b_d = b_q >> 1;
    end
    if (cmd_i.sub) begin
      if (diff_ba[WIDTH]) begin
        // a was larger: swap, keep the difference in b
        a_d = b_q;
        b_d = diff_ab;
      end else begin
        b_d = diff_ba[WIDTH-1:0];
      end
    end
    if (cmd_i.store) begin
      res_d = a_q << shift_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    shift_q <= shift_d;
    res_q   <= res_d;
  end

  assign status_o.a_zero = (a_q == '0);
  assign status_o.b_zero = (b_q == '0);
  assign status_o.a_odd  = a_q[0];
  assign status_o.b_odd  = b_q[0];

  assign divisor_o = DataW'(res_q);

endmodule

`default_nettype wire

[design/bgcd_ctrl.sv]
// Sequencer for the binary GCD core and output request valid.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire bgcd_pkg::status_t status_i,
  output bgcd_pkg::cmd_t         cmd_o
);
  import bgcd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVEN;
        end
      end
      ST_EVEN: begin
        if (status_i.a_zero || status_i.b_zero) begin
          cmd_o.merge = 1'b1;
          state_d     = ST_FINISH;
        end else if (!status_i.a_odd && !status_i.b_odd) begin
          cmd_o.halve_both = 1'b1;
        end else begin
          state_d = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!status_i.a_odd) begin
          cmd_o.halve_a = 1'b1;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.b_zero) begin
          state_d = ST_FINISH;
        end else if (!status_i.b_odd) begin
          cmd_o.halve_b = 1'b1;
        end else begin
          cmd_o.sub = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.store = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[design/binary_gcd_core.sv]
// Binary GCD core: top level joining sequencer and datapath.
// Each request runs a shift/subtract loop over the shared operand registers.
// Throughput: one request in flight; the next is taken once the result is
// in the output register. Reset clears the sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_gcd_core_assert.svh"

module binary_gcd_core #(
  parameter int unsigned WIDTH = bgcd_pkg::DefaultWidth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [bgcd_pkg::DataW-1:0] operand_a_i,
  input  wire logic [bgcd_pkg::DataW-1:0] operand_b_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [bgcd_pkg::DataW-1:0]      divisor_o
);
  import bgcd_pkg::*;

  cmd_t    cmd;
  status_t status;

  bgcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bgcd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .status_o    (status),
    .divisor_o   (divisor_o)
  );

  `BGCD_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `BGCD_ASSERT_NEXT(a_store_gives_valid, cmd.store, out_valid_o)
  `BGCD_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd))
  `BGCD_ASSERT_NOW(a_sub_on_odd, cmd.sub, status.a_odd && status.b_odd)

endmodule

`default_nettype wire
